>>> src/dics_pkg.sv
package dics_pkg;

    // item field widths
    localparam int OP_W      = 2;
    localparam int NODE_W    = 7;
    localparam int S_TDATA_W = 16;  // operation + node_id, padded to bytes
    localparam int M_TDATA_W = 8;   // hit + widest_node

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    // per-leaf state held by one cell
    typedef struct packed {
        logic covered;
        logic start;
    } leaf_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_GROW = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

>>> src/dics_cell.sv
module dics_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             shift_en,
    input  dics_pkg::leaf_t  d_in,
    output dics_pkg::leaf_t  q
);

    dics_pkg::leaf_t leaf_reg;

    // one leaf of the ring; takes its neighbor's leaf on every scan cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaf_reg <= '0;
        end else if (shift_en) begin
            leaf_reg <= d_in;
        end
    end

    assign q = leaf_reg;

endmodule

>>> src/dics_head.sv
module dics_head #(
    parameter int TREE_DEPTH = 6
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [dics_pkg::OP_W-1:0]        in_operation,
    input  logic [dics_pkg::NODE_W-1:0]      in_node_id,
    // result
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_hit,
    output logic [dics_pkg::NODE_W-1:0]      out_widest_node,
    // ring interface
    input  dics_pkg::leaf_t                  cur,
    input  dics_pkg::leaf_t                  nxt,
    output dics_pkg::leaf_t                  wb,
    output logic                             shift_en
);

    localparam int LW  = TREE_DEPTH;
    localparam int SHW = $clog2(TREE_DEPTH + 1);

    dics_pkg::state_t state_reg;
    dics_pkg::op_t    op_reg;

    logic [dics_pkg::NODE_W-1:0] node_reg;
    logic [LW-1:0] i_reg, lo_reg, hi_reg, a_reg, b_reg;
    logic [LW-1:0] left_reg, right_reg, e_reg;
    logic [LW:0]   w_reg;
    logic          prev_cov_reg, prev_st_reg, walk_reg, ok_reg;
    logic          hit_reg, mvalid_reg;
    logic [dics_pkg::NODE_W-1:0] widest_reg;

    // span decode of the incoming node
    logic [2:0]                  d_sel;
    logic                        span_ok;
    logic [SHW-1:0]              sh;
    logic [dics_pkg::NODE_W-1:0] offset;
    logic [LW-1:0]               lo_new, hi_new;
    logic [LW:0]                 w_new;

    always_comb begin
        d_sel = '0;
        for (int k = 0; k < dics_pkg::NODE_W; k++) begin
            if (in_node_id[k]) d_sel = 3'(k);
        end
        span_ok = (in_node_id != '0) && (int'(d_sel) <= TREE_DEPTH);
        sh      = SHW'(TREE_DEPTH) - SHW'(d_sel);
        offset  = in_node_id & ~(dics_pkg::NODE_W'(1) << d_sel);
        lo_new  = LW'(offset) << sh;
        w_new   = (LW + 1)'(1) << sh;
        hi_new  = lo_new + LW'(w_new - (LW + 1)'(1));
    end

    // scan of one leaf per cycle, highest leaf first
    logic          in_span, at_lo, active, cont, ns_here, top_leaf;
    logic [LW-1:0] e_cur;
    logic [LW:0]   hip1;

    always_comb begin
        in_span  = (i_reg >= lo_reg) && (i_reg <= hi_reg);
        at_lo    = (i_reg == lo_reg);
        active   = at_lo || walk_reg;
        cont     = cur.covered && (i_reg != '0) && !cur.start && nxt.covered;
        ns_here  = active && !cont;        // this leaf starts the merged run
        top_leaf = &i_reg;
        e_cur    = (!top_leaf && prev_cov_reg && !prev_st_reg) ? e_reg : i_reg;
        hip1     = {1'b0, hi_reg} + (LW + 1)'(1);

        wb = cur;
        case (op_reg)
            dics_pkg::OP_INSERT: begin
                if (in_span) begin
                    wb.covered = 1'b1;
                    wb.start   = ns_here;
                end else if (ns_here) begin
                    wb.start   = 1'b1;
                end
            end
            dics_pkg::OP_REMOVE: begin
                if (in_span) begin
                    wb = '0;
                end else if ({1'b0, i_reg} == hip1) begin
                    wb.start = cur.start | cur.covered;
                end
            end
            default: wb = cur;
        endcase
    end

    // growth toward the root
    logic [LW:0] b_sum, l_sum;
    logic        grow_stop;

    always_comb begin
        b_sum = {1'b0, b_reg} + w_reg;
        l_sum = {1'b0, left_reg} + w_reg;
        if (node_reg == dics_pkg::NODE_W'(1)) begin
            grow_stop = 1'b1;
        end else if (!node_reg[0]) begin
            grow_stop = b_sum > {1'b0, right_reg};
        end else begin
            grow_stop = {1'b0, a_reg} < l_sum;
        end
    end

    // finished item moves into the result register once the old one is gone
    logic res_load;
    assign res_load = (state_reg == dics_pkg::ST_DONE) && (!mvalid_reg || out_ready);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dics_pkg::ST_IDLE;
            mvalid_reg <= 1'b0;
            walk_reg   <= 1'b0;
        end else begin
            if (res_load) begin
                mvalid_reg <= 1'b1;
            end else if (out_ready) begin
                mvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                dics_pkg::ST_IDLE: begin
                    if (in_valid) begin
                        op_reg   <= dics_pkg::op_t'(in_operation);
                        node_reg <= in_node_id;
                        lo_reg   <= lo_new;
                        hi_reg   <= hi_new;
                        a_reg    <= lo_new;
                        b_reg    <= hi_new;
                        w_reg    <= w_new;
                        i_reg    <= '1;
                        walk_reg <= 1'b0;
                        if (span_ok && (in_operation == dics_pkg::OP_INSERT ||
                                        in_operation == dics_pkg::OP_REMOVE ||
                                        in_operation == dics_pkg::OP_QUERY)) begin
                            ok_reg    <= 1'b1;
                            state_reg <= dics_pkg::ST_SCAN;
                        end else begin
                            ok_reg    <= 1'b0;
                            state_reg <= dics_pkg::ST_DONE;
                        end
                    end
                end
                dics_pkg::ST_SCAN: begin
                    walk_reg     <= active && cont;
                    e_reg        <= e_cur;
                    prev_cov_reg <= cur.covered;
                    prev_st_reg  <= cur.start;
                    if (i_reg == hi_reg) right_reg <= e_cur;
                    if (ns_here) left_reg <= i_reg;
                    if (in_span && (!cur.covered || (!at_lo && cur.start))) ok_reg <= 1'b0;
                    i_reg <= i_reg - LW'(1);
                    if (i_reg == '0) begin
                        state_reg <= (op_reg == dics_pkg::OP_QUERY) ? dics_pkg::ST_GROW
                                                                   : dics_pkg::ST_DONE;
                    end
                end
                dics_pkg::ST_GROW: begin
                    if (!ok_reg || grow_stop) begin
                        state_reg <= dics_pkg::ST_DONE;
                    end else begin
                        if (!node_reg[0]) b_reg <= LW'(b_sum);
                        else              a_reg <= a_reg - LW'(w_reg);
                        node_reg <= node_reg >> 1;
                        w_reg    <= w_reg << 1;
                    end
                end
                dics_pkg::ST_DONE: begin
                    if (res_load) begin
                        state_reg <= dics_pkg::ST_IDLE;
                    end
                end
                default: state_reg <= dics_pkg::ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            hit_reg    <= ok_reg && (op_reg == dics_pkg::OP_QUERY);
            widest_reg <= (ok_reg && (op_reg == dics_pkg::OP_QUERY)) ? node_reg : '0;
        end
    end

    assign in_ready        = (state_reg == dics_pkg::ST_IDLE);
    assign shift_en        = (state_reg == dics_pkg::ST_SCAN);
    assign out_valid       = mvalid_reg;
    assign out_hit         = hit_reg;
    assign out_widest_node = widest_reg;

endmodule

>>> src/dyadic_interval_cover_set.sv
// channel | dir | tdata fields (low bit up)                     | handshake
// s_      | in  | operation[1:0], node_id[8:2], zero pad [15:9]  | s_tvalid/s_tready
// m_      | out | hit[0], widest_node[7:1]                       | m_tvalid/m_tready
//
// An insert or remove is accepted, then every leaf is scanned in turn as the ring
// rotates once past the head, and then the result is loaded. A query adds growth
// steps toward the root after the scan; an invalid node or code skips the scan.
// Reset empties the set. One item is in work at a time; a new item is taken while a
// result waits, and its result is held back until m_tready frees it.
module dyadic_interval_cover_set #(
    parameter int TREE_DEPTH = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dics_pkg::S_TDATA_W-1:0]    s_tdata,   // operation, node_id
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dics_pkg::M_TDATA_W-1:0]    m_tdata    // hit, widest_node
);

    localparam int LEAF_N = 1 << TREE_DEPTH;

    dics_pkg::leaf_t chain_q [LEAF_N];
    dics_pkg::leaf_t wb;
    logic            shift_en;
    logic            hit;
    logic [dics_pkg::NODE_W-1:0] widest_node;

    // leaf ring: head writes into cell 0, reads the top cell and its neighbor
    for (genvar j = 0; j < LEAF_N; j++) begin : g_cell
        if (j == 0) begin : g_first
            dics_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (wb),
                .q        (chain_q[j])
            );
        end else begin : g_rest
            dics_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (chain_q[j-1]),
                .q        (chain_q[j])
            );
        end
    end

    dics_head #(
        .TREE_DEPTH (TREE_DEPTH)
    ) u_head (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .in_operation    (s_tdata[dics_pkg::OP_W-1:0]),
        .in_node_id      (s_tdata[dics_pkg::OP_W +: dics_pkg::NODE_W]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_hit         (hit),
        .out_widest_node (widest_node),
        .cur             (chain_q[LEAF_N-1]),
        .nxt             (chain_q[LEAF_N-2]),
        .wb              (wb),
        .shift_en        (shift_en)
    );

    assign m_tdata = {widest_node, hit};

endmodule

>>> src/dics_checker.sv
module dics_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dics_pkg::M_TDATA_W-1:0]    m_tdata
);

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a miss or a non-query result carries no node
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == '0)
        else $error("node reported without hit");

    // a hit always names a real node
    a_hit_node: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[7:1] != '0)
        else $error("hit with node zero");

    // one item in work at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

endmodule

bind dyadic_interval_cover_set dics_checker u_dics_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_dyadic_interval_cover_set.sv
module tb_dyadic_interval_cover_set;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_DEPTH     = 6;
    localparam int LEAF_COUNT     = 1 << TREE_DEPTH;
    localparam int ITEM_LATENCY   = LEAF_COUNT + TREE_DEPTH + 2;
    localparam int DRAIN_CYCLES   = 2 * ITEM_LATENCY;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 625;
    localparam int IDLE_PCT       = 23;
    localparam int CALM_FIRST     = 300;
    localparam int CALM_LAST      = 420;

    // code outside the defined operations
    localparam logic [dics_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic                        hit;
        logic [dics_pkg::NODE_W-1:0] widest;
    } cover_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dics_pkg::S_TDATA_W-1:0] s_tdata  = '0;  // operation[1:0], node_id[8:2], zero pad
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dics_pkg::M_TDATA_W-1:0] m_tdata;        // hit[0], widest_node[7:1]

    // predictor state: one bit per leaf
    logic [LEAF_COUNT-1:0] leaf_cover = '0;
    logic [LEAF_COUNT-1:0] leaf_head  = '0;

    logic [dics_pkg::S_TDATA_W-1:0] pending_items[$];
    cover_result_t                  expected_results[$];

    int  total_items;
    int  items_in    = 0;
    int  results_out = 0;
    int  query_count = 0;
    int  hit_count   = 0;
    int  noise_count;
    int  errors      = 0;
    int  idle_cycles = 0;
    bit  item_taken  = 1'b0;

    dyadic_interval_cover_set #(
        .TREE_DEPTH (TREE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // walk left from leaf i to the first leaf of its interval
    function automatic int run_first(int i);
        while (i > 0 && !leaf_head[i] && leaf_cover[i-1]) i--;
        return i;
    endfunction

    // walk right from leaf i to the last leaf of its interval
    function automatic int run_last(int i);
        while (i + 1 < LEAF_COUNT && leaf_cover[i+1] && !leaf_head[i+1]) i++;
        return i;
    endfunction

    // apply one item to the leaf vectors and work out its result
    task automatic apply_cover_item(input logic [dics_pkg::OP_W-1:0] op,
                                    input logic [dics_pkg::NODE_W-1:0] node,
                                    output cover_result_t res);
        int d;
        int nd;
        int lo;
        int w;
        int hi;
        int ns;
        int ne;
        int lft;
        int rgt;
        int a;
        int b;
        bit ok;
        res = '0;
        if (node == '0) return;
        nd = node;
        d  = 0;
        while ((nd >> (d + 1)) != 0) d++;
        w  = 1 << (TREE_DEPTH - d);
        lo = (nd - (1 << d)) << (TREE_DEPTH - d);
        hi = lo + w - 1;
        case (op)
            dics_pkg::OP_INSERT: begin
                // merge with every interval sharing a leaf
                ns = leaf_cover[lo] ? run_first(lo) : lo;
                ne = leaf_cover[hi] ? run_last(hi) : hi;
                for (int i = ns; i <= ne; i++) begin
                    leaf_cover[i] = 1'b1;
                    leaf_head[i]  = (i == ns);
                end
            end
            dics_pkg::OP_REMOVE: begin
                for (int i = lo; i <= hi; i++) begin
                    leaf_cover[i] = 1'b0;
                    leaf_head[i]  = 1'b0;
                end
                // right remnant gets its own start
                if (hi + 1 < LEAF_COUNT && leaf_cover[hi+1]) leaf_head[hi+1] = 1'b1;
            end
            dics_pkg::OP_QUERY: begin
                ok = 1'b1;
                for (int i = lo; i <= hi; i++) begin
                    if (!leaf_cover[i]) ok = 1'b0;
                    if (i != lo && leaf_head[i]) ok = 1'b0;
                end
                if (ok) begin
                    lft = run_first(lo);
                    rgt = run_last(hi);
                    a   = lo;
                    b   = hi;
                    // climb while the sibling stays inside the interval
                    while (nd > 1) begin
                        if ((nd & 1) == 0) begin
                            if (b + w > rgt) break;
                            b += w;
                        end else begin
                            if (a < w || a - w < lft) break;
                            a -= w;
                        end
                        nd = nd >> 1;
                        w  = w << 1;
                    end
                    res.hit    = 1'b1;
                    res.widest = nd[dics_pkg::NODE_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    function automatic void queue_item(logic [dics_pkg::OP_W-1:0] op,
                                       logic [dics_pkg::NODE_W-1:0] node);
        pending_items.insert(pending_items.size(),
            {{(dics_pkg::S_TDATA_W - dics_pkg::OP_W - dics_pkg::NODE_W){1'b0}}, node, op});
    endfunction

    function automatic logic [dics_pkg::NODE_W-1:0] random_node();
        int d;
        d = $urandom_range(TREE_DEPTH, 0);
        return dics_pkg::NODE_W'((1 << d) + $urandom_range((1 << d) - 1, 0));
    endfunction

    // driver and ready generator: change at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && !item_taken) begin
                // hold the offered item
            end else if (pending_items.size() > 0 &&
                         ((items_in >= CALM_FIRST && items_in < CALM_LAST) ||
                          $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_items.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= (results_out >= CALM_FIRST && results_out < CALM_LAST) ||
                        ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // acceptance, prediction, checking and watchdog at the rising edge
    always @(posedge aclk) begin
        cover_result_t exp_res;
        cover_result_t got;
        bit            moved;
        moved      = 1'b0;
        item_taken = s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                apply_cover_item(s_tdata[dics_pkg::OP_W-1:0],
                                 s_tdata[dics_pkg::OP_W +: dics_pkg::NODE_W], exp_res);
                expected_results.insert(expected_results.size(), exp_res);
                if (s_tdata[dics_pkg::OP_W-1:0] == dics_pkg::OP_QUERY &&
                    s_tdata[dics_pkg::OP_W +: dics_pkg::NODE_W] != '0)
                    query_count++;
                if (exp_res.hit) hit_count++;
                items_in++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[dics_pkg::NODE_W:1]};
                results_out++;
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result hit=%0b widest_node=%0d",
                             $time, got.hit, got.widest);
                    errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got.hit !== exp_res.hit) begin
                        $display("%0t: hit mismatch, expected %0b actual %0b",
                                 $time, exp_res.hit, got.hit);
                        errors++;
                    end
                    if (got.widest !== exp_res.widest) begin
                        $display("%0t: widest_node mismatch, expected %0d actual %0d",
                                 $time, exp_res.widest, got.widest);
                        errors++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, expected_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [dics_pkg::OP_W-1:0]   op;
        logic [dics_pkg::NODE_W-1:0] node;
        int                          r;
        aresetn     = 1'b0;
        noise_count = 0;

        // directed: empty set, touching vs overlapping, remnants, root and leaf edges
        queue_item(dics_pkg::OP_REMOVE, 7'd1);
        queue_item(dics_pkg::OP_QUERY,  7'd1);
        queue_item(dics_pkg::OP_INSERT, 7'd64);
        queue_item(dics_pkg::OP_INSERT, 7'd65);
        queue_item(dics_pkg::OP_QUERY,  7'd32);   // two touching intervals, no hit
        queue_item(dics_pkg::OP_QUERY,  7'd65);
        queue_item(dics_pkg::OP_INSERT, 7'd32);   // overlap merges them
        queue_item(dics_pkg::OP_QUERY,  7'd64);
        queue_item(dics_pkg::OP_INSERT, 7'd33);
        queue_item(dics_pkg::OP_INSERT, 7'd17);
        queue_item(dics_pkg::OP_INSERT, 7'd8);
        queue_item(dics_pkg::OP_QUERY,  7'd66);   // grows from a leaf on both sides
        queue_item(dics_pkg::OP_REMOVE, 7'd66);   // left and right remnants
        queue_item(dics_pkg::OP_QUERY,  7'd67);
        queue_item(dics_pkg::OP_QUERY,  7'd64);
        queue_item(dics_pkg::OP_INSERT, 7'd1);
        queue_item(dics_pkg::OP_QUERY,  7'd127);
        queue_item(dics_pkg::OP_QUERY,  7'd64);
        queue_item(dics_pkg::OP_REMOVE, 7'd127);  // no leaf after the last one
        queue_item(dics_pkg::OP_REMOVE, 7'd2);
        queue_item(dics_pkg::OP_QUERY,  7'd3);
        queue_item(dics_pkg::OP_QUERY,  7'd6);
        queue_item(OP_RESERVED, 7'd5);
        queue_item(dics_pkg::OP_INSERT, 7'd0);
        queue_item(OP_RESERVED, 7'd0);
        queue_item(dics_pkg::OP_QUERY,  7'd0);
        noise_count = 4;

        // random mix, mostly valid operations over all depths
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            r = $urandom_range(99);
            if (r < 5) begin
                noise_count++;
                if ($urandom_range(1)) begin
                    op   = OP_RESERVED;
                    node = dics_pkg::NODE_W'($urandom_range(127));
                end else begin
                    op   = dics_pkg::OP_W'($urandom_range(2));
                    node = '0;
                end
            end else begin
                op   = (r < 40) ? dics_pkg::OP_INSERT :
                       (r < 62) ? dics_pkg::OP_REMOVE : dics_pkg::OP_QUERY;
                node = random_node();
            end
            queue_item(op, node);
        end
        total_items = pending_items.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // wait for every result, then let the block settle
        do @(negedge aclk);
        while (items_in < total_items || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Ran %0d items (%0d valid queries, %0d hits, %0d reserved or node-zero),",
                 items_in, query_count, hit_count, noise_count);
        $display("checked %0d results with %0d mismatches.", results_out, errors);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
